@@ hdl/flag_frame_unescape_xor_check_core_defines.svh @@
// Assertion macros shared by the flag frame deframer RTL.
`ifndef FLAG_FRAME_UNESCAPE_XOR_CHECK_CORE_DEFINES_SVH
`define FLAG_FRAME_UNESCAPE_XOR_CHECK_CORE_DEFINES_SVH

// The condition must never hold while out of reset.
`define FFUX_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define FFUX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define FFUX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/ffux_pkg.sv @@
// Package with the constants, status codes and state types of the deframer.
`default_nettype none

package ffux_pkg;

  // Width of the raw frame byte counter.
  localparam int COUNT_BITS = 11;
  // Width of the minimum length register.
  localparam int MIN_LEN_BITS = 11;
  // Width used when comparing the count with the minimum length.
  localparam int CMP_BITS = (COUNT_BITS > MIN_LEN_BITS) ? COUNT_BITS : MIN_LEN_BITS;
  localparam logic [MIN_LEN_BITS-1:0] MIN_LEN_RESET = MIN_LEN_BITS'(15);

  // Register file of the configuration port.
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_MIN_LEN = 1'b0;

  // Link bytes.
  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_FLAG  = 8'h02;
  localparam logic [7:0] ESC_ESC   = 8'h01;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_BADESC = 2'd2,
    ST_CHECK  = 2'd3
  } status_t;

  // Frame tracking state kept between bytes.
  typedef struct packed {
    logic                  in_frame;
    logic                  esc_pending;
    logic [7:0]            running_xor;
    logic [COUNT_BITS-1:0] raw_count;
    logic                  esc_error;
  } frame_state_t;

  // One result beat produced by a byte.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       frame_end;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/ffux_step.sv @@
// Per-byte deframing logic: unescaping, checksum, counting and frame status.
`default_nettype none

module ffux_step (
  input  wire ffux_pkg::frame_state_t           state_cur,
  input  wire logic [7:0]                       raw_byte,
  input  wire logic [ffux_pkg::MIN_LEN_BITS-1:0] min_len,
  output ffux_pkg::frame_state_t                state_nxt,
  output ffux_pkg::result_t                     result
);
  import ffux_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] count_inc;
  logic                  err_close;
  logic                  too_short;

  // Saturating count of raw bytes in the open frame.
  assign count_inc = (state_cur.raw_count == COUNT_MAX) ? state_cur.raw_count
                                                        : state_cur.raw_count + 1'b1;
  assign err_close = state_cur.esc_error | state_cur.esc_pending;
  assign too_short = CMP_BITS'(count_inc) < CMP_BITS'(min_len);

  // Next state and result for one accepted byte.
  always_comb begin
    state_nxt        = state_cur;
    result.valid     = 1'b0;
    result.data      = 8'h00;
    result.frame_end = 1'b0;
    result.status    = ST_OK;
    if (!state_cur.in_frame) begin
      // Outside a frame only an opening flag matters.
      if (raw_byte == FLAG_BYTE) begin
        state_nxt.in_frame    = 1'b1;
        state_nxt.esc_pending = 1'b0;
        state_nxt.esc_error   = 1'b0;
        state_nxt.running_xor = 8'h00;
        state_nxt.raw_count   = COUNT_BITS'(1);
      end
    end else if (raw_byte == FLAG_BYTE) begin
      // Closing flag: report the frame status and return to idle.
      state_nxt        = '0;
      result.valid     = 1'b1;
      result.frame_end = 1'b1;
      if (too_short) begin
        result.status = ST_SHORT;
      end else if (err_close) begin
        result.status = ST_BADESC;
      end else if (state_cur.running_xor != 8'h00) begin
        result.status = ST_CHECK;
      end else begin
        result.status = ST_OK;
      end
    end else begin
      state_nxt.raw_count = count_inc;
      if (state_cur.esc_pending) begin
        // Second byte of an escape pair.
        state_nxt.esc_pending = 1'b0;
        if (raw_byte == ESC_FLAG) begin
          result.valid = 1'b1;
          result.data  = FLAG_BYTE;
        end else if (raw_byte == ESC_ESC) begin
          result.valid = 1'b1;
          result.data  = ESC_BYTE;
        end else begin
          state_nxt.esc_error = 1'b1;
        end
      end else if (raw_byte == ESC_BYTE) begin
        state_nxt.esc_pending = 1'b1;
      end else begin
        result.valid = 1'b1;
        result.data  = raw_byte;
      end
      if (result.valid) begin
        state_nxt.running_xor = state_cur.running_xor ^ result.data;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/flag_frame_unescape_xor_check_core.sv @@
// Flag-delimited, byte-stuffed frame receiver with XOR checksum check.
//
// Input channel: one raw link byte per beat on in_raw_byte, taken at a rising
// edge where in_valid is high and in_stall is low. Bytes outside a frame are
// dropped; frames open and close on 0x7e and 0x7d pairs are unescaped.
// Output channel: each unescaped byte comes out as a data beat; the closing
// flag gives a status beat with out_frame_end high and out_byte zero.
// Each accepted byte waits in the input register; its result is then
// registered in the output register, or in the skid register while stalled.
// One byte is accepted in every cycle while the receiver
// takes beats; the rate is set by the single input register stage and the
// per-byte decode logic behind it.
// When the receiver stalls, results fill the output register and then a skid
// register; the input channel stalls only once both are full and a byte is
// waiting in the input register.
// Synchronous reset empties all stages, closes any open frame and sets
// min_raw_length to 15. The APB port holds min_raw_length at byte address 0
// and should be written only while the block is idle.
`default_nettype none

module flag_frame_unescape_xor_check_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Raw byte input channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_raw_byte,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_byte,
  output logic                                   out_frame_end,
  output logic [1:0]                             out_status,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ffux_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [ffux_pkg::DATA_BITS-1:0]    pwdata,
  output logic [ffux_pkg::DATA_BITS-1:0]         prdata,
  output logic                                   pready
);
  import ffux_pkg::*;

  `include "flag_frame_unescape_xor_check_core_defines.svh"

  logic [MIN_LEN_BITS-1:0] min_len_r, min_len_nxt;
  logic                    in_valid_r, in_valid_nxt;
  logic [7:0]              in_byte_r, in_byte_nxt;
  frame_state_t            state_r, state_nxt, step_state;
  result_t                 step_res;
  result_t                 out_r, out_nxt;
  result_t                 skid_r, skid_nxt;
  logic                    in_accept;
  logic                    advance;
  logic                    res_valid;
  logic                    out_take;
  logic                    cfg_write;
  logic                    reg_sel;

  // Configuration register access.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_BITS-1];
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    min_len_nxt = min_len_r;
    if (cfg_write && (reg_sel == REG_MIN_LEN)) begin
      min_len_nxt = pwdata[MIN_LEN_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_MIN_LEN) begin
      prdata = DATA_BITS'(min_len_r);
    end
  end

  // Input register stage; it moves on whenever the skid register is free.
  assign advance   = in_valid_r & ~skid_r.valid;
  assign in_stall  = in_valid_r & skid_r.valid;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_raw_byte;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Per-byte deframing.
  ffux_step u_step (
    .state_cur (state_r),
    .raw_byte  (in_byte_r),
    .min_len   (min_len_r),
    .state_nxt (step_state),
    .result    (step_res)
  );

  assign state_nxt = advance ? step_state : state_r;
  assign res_valid = advance & step_res.valid;

  // Output register with a skid register behind it.
  assign out_take = out_r.valid & ~out_stall;

  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (!out_r.valid || out_take) begin
      if (skid_r.valid) begin
        out_nxt = skid_r;
      end else begin
        out_nxt       = step_res;
        out_nxt.valid = res_valid;
      end
      skid_nxt.valid = 1'b0;
    end else if (res_valid) begin
      skid_nxt       = step_res;
      skid_nxt.valid = 1'b1;
    end
  end

  assign out_valid     = out_r.valid;
  assign out_byte      = out_r.data;
  assign out_frame_end = out_r.frame_end;
  assign out_status    = out_r.status;

  // Pipeline and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r  <= MIN_LEN_RESET;
      in_valid_r <= 1'b0;
      in_byte_r  <= 8'h00;
      state_r    <= '0;
      out_r      <= '0;
      skid_r     <= '0;
    end else begin
      min_len_r  <= min_len_nxt;
      in_valid_r <= in_valid_nxt;
      in_byte_r  <= in_byte_nxt;
      state_r    <= state_nxt;
      out_r      <= out_nxt;
      skid_r     <= skid_nxt;
    end
  end

  // Checks on the pipeline and frame state.
  `FFUX_ASSERT_NEVER(a_skid_behind_out, skid_r.valid && !out_r.valid, "skid full, output empty")
  `FFUX_ASSERT_NEXT(a_result_lands, res_valid, out_r.valid, "result beat was lost")
  `FFUX_ASSERT_IMPL(a_esc_in_frame, state_r.esc_pending, state_r.in_frame, "escape outside frame")
  `FFUX_ASSERT_IMPL(a_end_zero, out_valid && out_frame_end, out_byte == 8'h00, "status with data")

endmodule

`default_nettype wire
